// File: rtl/core/ggvc_pkg.sv
package ggvc_pkg;

    localparam int CORDIC_STEPS = 17;
    localparam int ROOT_STEPS   = 32;
    localparam int DIV_STEPS    = 15;

    localparam logic signed [20:0] PI_Q16     = 21'sd205887;
    localparam logic signed [18:0] PI_Q13     = 19'sd25736;
    localparam logic signed [18:0] TWO_PI_Q13 = 19'sd51472;

    // floor(2^17 / 10); the quotient it gives is low by at most one.
    localparam logic [13:0] RECIP10 = 14'd13107;

    localparam logic [14:0] RST_MAX_LINEAR = 15'd2949;
    localparam logic [14:0] RST_MAX_TURN   = 15'd5120;
    localparam logic [30:0] RST_ARRIVE     = 31'd14418;
    localparam logic [30:0] RST_SLOWDOWN   = 31'd65536;
    localparam logic [30:0] RST_KEEP_AWAY  = 31'd81920;
    localparam logic [14:0] RST_ALIGNED    = 15'd1475;
    localparam logic [2:0]  RST_NEGATE     = 3'd6;

    localparam logic [1:0] DS_DRIVE     = 2'd0;
    localparam logic [1:0] DS_NOT_READY = 2'd1;
    localparam logic [1:0] DS_ARRIVED   = 2'd2;
    localparam logic [1:0] DS_SEPARATE  = 2'd3;

    localparam logic [2:0] REG_MAX_LINEAR = 3'd0;
    localparam logic [2:0] REG_MAX_TURN   = 3'd1;
    localparam logic [2:0] REG_ARRIVE     = 3'd2;
    localparam logic [2:0] REG_SLOWDOWN   = 3'd3;
    localparam logic [2:0] REG_KEEP_AWAY  = 3'd4;
    localparam logic [2:0] REG_ALIGNED    = 3'd5;
    localparam logic [2:0] REG_NEGATE     = 3'd6;

    typedef struct packed {
        logic signed [31:0] own_x;
        logic signed [31:0] own_y;
        logic signed [15:0] own_heading;
        logic signed [31:0] peer_x;
        logic signed [31:0] peer_y;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [31:0] anchor_x;
        logic signed [31:0] anchor_y;
        logic [3:0]         valid_bits;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] linear_speed;
        logic signed [15:0] turn_rate;
        logic [1:0]         drive_status;
    } t_out_item;

    typedef struct packed {
        logic [14:0] max_linear_speed;
        logic [14:0] max_turn_rate;
        logic [30:0] arrive_radius;
        logic [30:0] slowdown_radius;
        logic [30:0] keep_away_radius;
        logic [14:0] aligned_window;
        logic [2:0]  negate_flags;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_IDLE, OP_LOAD, OP_PREP, OP_STOP, OP_SQ_A, OP_SQ_B, OP_ROOT, OP_KEEP_D,
        OP_CINIT, OP_CSTEP, OP_ERR, OP_MAG_MUL, OP_MAG_FIX, OP_LIN_MUL,
        OP_DIV_INIT, OP_DIV_STEP, OP_LIN_FIN
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_SQ_A, S_SQ_B, S_ROOT, S_DGOAL, S_DPEER, S_CINIT,
        S_CSTEP, S_ERR, S_MAG_MUL, S_MAG_FIX, S_LIN_MUL, S_DIV_INIT, S_DIV,
        S_LIN_FIN, S_OUT
    } t_state;

    typedef struct packed {
        t_op        op;
        logic       peer;
        logic [1:0] code;
        logic [4:0] idx;
    } t_cmd;

    typedef struct packed {
        logic ready;
        logic near_goal;
        logic near_peer;
        logic peer_check;
    } t_stat;

    // Arctangent of 2^-i in units of 2^-16 rad.
    function automatic logic signed [20:0] atan_entry(input logic [4:0] i);
        logic signed [20:0] v;
        case (i)
            5'd0:    v = 21'sd51472;
            5'd1:    v = 21'sd30386;
            5'd2:    v = 21'sd16055;
            5'd3:    v = 21'sd8150;
            5'd4:    v = 21'sd4091;
            5'd5:    v = 21'sd2047;
            5'd6:    v = 21'sd1024;
            5'd7:    v = 21'sd512;
            5'd8:    v = 21'sd256;
            5'd9:    v = 21'sd128;
            5'd10:   v = 21'sd64;
            5'd11:   v = 21'sd32;
            5'd12:   v = 21'sd16;
            5'd13:   v = 21'sd8;
            5'd14:   v = 21'sd4;
            5'd15:   v = 21'sd2;
            5'd16:   v = 21'sd1;
            default: v = 21'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/ggvc_regs.sv
module ggvc_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output ggvc_pkg::t_cfg o_cfg
);
    import ggvc_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_linear_speed <= RST_MAX_LINEAR;
            r_cfg.max_turn_rate    <= RST_MAX_TURN;
            r_cfg.arrive_radius    <= RST_ARRIVE;
            r_cfg.slowdown_radius  <= RST_SLOWDOWN;
            r_cfg.keep_away_radius <= RST_KEEP_AWAY;
            r_cfg.aligned_window   <= RST_ALIGNED;
            r_cfg.negate_flags     <= RST_NEGATE;
        end else if (wr) begin
            case (idx)
                REG_MAX_LINEAR: r_cfg.max_linear_speed <= pwdata[14:0];
                REG_MAX_TURN:   r_cfg.max_turn_rate    <= pwdata[14:0];
                REG_ARRIVE:     r_cfg.arrive_radius    <= pwdata[30:0];
                REG_SLOWDOWN:   r_cfg.slowdown_radius  <= pwdata[30:0];
                REG_KEEP_AWAY:  r_cfg.keep_away_radius <= pwdata[30:0];
                REG_ALIGNED:    r_cfg.aligned_window   <= pwdata[14:0];
                REG_NEGATE:     r_cfg.negate_flags     <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MAX_LINEAR: prdata = {17'd0, r_cfg.max_linear_speed};
            REG_MAX_TURN:   prdata = {17'd0, r_cfg.max_turn_rate};
            REG_ARRIVE:     prdata = {1'b0, r_cfg.arrive_radius};
            REG_SLOWDOWN:   prdata = {1'b0, r_cfg.slowdown_radius};
            REG_KEEP_AWAY:  prdata = {1'b0, r_cfg.keep_away_radius};
            REG_ALIGNED:    prdata = {17'd0, r_cfg.aligned_window};
            REG_NEGATE:     prdata = {29'd0, r_cfg.negate_flags};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/core/ggvc_ctrl.sv
module ggvc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  ggvc_pkg::t_stat i_stat,
    output ggvc_pkg::t_cmd  o_cmd
);
    import ggvc_pkg::*;

    localparam logic [4:0] ROOT_LAST   = 5'(ROOT_STEPS - 1);
    localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);
    localparam logic [4:0] DIV_LAST    = 5'(DIV_STEPS - 1);

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_peer, n_peer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 5'd0;
            r_peer  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_peer  <= n_peer;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_peer      = r_peer;
        o_out_valid = 1'b0;
        o_cmd       = '{op: OP_IDLE, peer: r_peer, code: DS_DRIVE, idx: r_cnt};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                if (!i_stat.ready) begin
                    o_cmd.op   = OP_STOP;
                    o_cmd.code = DS_NOT_READY;
                    n_state    = S_OUT;
                end else begin
                    o_cmd.op = OP_PREP;
                    n_peer   = 1'b0;
                    n_state  = S_SQ_A;
                end
            end
            S_SQ_A: begin
                o_cmd.op = OP_SQ_A;
                n_state  = S_SQ_B;
            end
            S_SQ_B: begin
                o_cmd.op = OP_SQ_B;
                n_cnt    = 5'd0;
                n_state  = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.op = OP_ROOT;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == ROOT_LAST) begin
                    n_state = r_peer ? S_DPEER : S_DGOAL;
                end
            end
            S_DGOAL: begin
                if (i_stat.near_goal) begin
                    o_cmd.op   = OP_STOP;
                    o_cmd.code = DS_ARRIVED;
                    n_state    = S_OUT;
                end else begin
                    o_cmd.op = OP_KEEP_D;
                    if (i_stat.peer_check) begin
                        n_peer  = 1'b1;
                        n_state = S_SQ_A;
                    end else begin
                        n_state = S_CINIT;
                    end
                end
            end
            S_DPEER: begin
                if (i_stat.near_peer) begin
                    o_cmd.op   = OP_STOP;
                    o_cmd.code = DS_SEPARATE;
                    n_state    = S_OUT;
                end else begin
                    n_state = S_CINIT;
                end
            end
            S_CINIT: begin
                o_cmd.op = OP_CINIT;
                n_cnt    = 5'd0;
                n_state  = S_CSTEP;
            end
            S_CSTEP: begin
                o_cmd.op = OP_CSTEP;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == CORDIC_LAST) begin
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.op = OP_ERR;
                n_state  = S_MAG_MUL;
            end
            S_MAG_MUL: begin
                o_cmd.op = OP_MAG_MUL;
                n_state  = S_MAG_FIX;
            end
            S_MAG_FIX: begin
                o_cmd.op = OP_MAG_FIX;
                n_state  = S_LIN_MUL;
            end
            S_LIN_MUL: begin
                o_cmd.op = OP_LIN_MUL;
                n_state  = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.op = OP_DIV_INIT;
                n_cnt    = 5'd0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_LIN_FIN;
                end
            end
            S_LIN_FIN: begin
                o_cmd.op = OP_LIN_FIN;
                n_state  = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_PREP))
        else $error("accepted transfer did not start the sequence");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result is pending");

    a_cordic_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CSTEP) |-> (r_cnt <= CORDIC_LAST))
        else $error("rotation index out of range");

    a_result_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after a transfer");

endmodule

// File: rtl/core/ggvc_dp.sv
module ggvc_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ggvc_pkg::t_in_item  i_in,
    input  ggvc_pkg::t_cfg      i_cfg,
    input  ggvc_pkg::t_cmd      i_cmd,
    output ggvc_pkg::t_stat     o_stat,
    output ggvc_pkg::t_out_item o_res
);
    import ggvc_pkg::*;

    t_in_item           r_in;
    logic [31:0]        r_off_x, r_off_y;
    logic               r_latched;
    logic signed [32:0] r_dx, r_dy, r_px, r_py;
    logic [63:0]        r_acc;
    logic [33:0]        r_rem;
    logic [31:0]        r_root;
    logic [32:0]        r_d;
    logic signed [35:0] r_cx, r_cy;
    logic signed [20:0] r_cz;
    logic signed [18:0] r_err;
    logic [14:0]        r_abs;
    logic [17:0]        r_v;
    logic [31:0]        r_prod;
    logic signed [15:0] r_ang;
    logic [45:0]        r_num;
    logic [30:0]        r_drem;
    logic [14:0]        r_dlow;
    logic [14:0]        r_q;
    t_out_item          r_res;

    // World position and differences to goal and peer.
    logic [31:0]        wx, wy;
    logic signed [32:0] dx, dy, px, py;
    always_comb begin
        wx = r_in.own_x + r_off_x;
        wy = r_in.own_y + r_off_y;
        dx = {r_in.goal_x[31], r_in.goal_x} - {wx[31], wx};
        dy = {r_in.goal_y[31], r_in.goal_y} - {wy[31], wy};
        px = {wx[31], wx} - {r_in.peer_x[31], r_in.peer_x};
        py = {wy[31], wy} - {r_in.peer_y[31], r_in.peer_y};
    end

    // Half magnitude of the selected difference, then its square.
    logic signed [32:0] sel_a, sel_b, sel;
    logic [32:0]        mag;
    logic [31:0]        half;
    logic [63:0]        sq;
    always_comb begin
        sel_a = i_cmd.peer ? r_px : r_dx;
        sel_b = i_cmd.peer ? r_py : r_dy;
        sel   = (i_cmd.op == OP_SQ_A) ? sel_a : sel_b;
        mag   = sel[32] ? (33'd0 - sel) : sel;
        half  = mag[32:1];
        sq    = half * half;
    end

    // One root digit per cycle.
    logic [35:0] rt, trial;
    logic        rt_ge;
    always_comb begin
        rt    = {r_rem, r_acc[63:62]};
        trial = {2'b00, r_root, 2'b01};
        rt_ge = (rt >= trial);
    end

    // Rotation step.
    logic signed [35:0] xs, ys;
    logic signed [20:0] ang_step;
    always_comb begin
        xs       = r_cx >>> i_cmd.idx;
        ys       = r_cy >>> i_cmd.idx;
        ang_step = atan_entry(i_cmd.idx);
    end

    // Heading error, rounded to Q3.13 and wrapped into plus or minus pi.
    logic signed [20:0] zr;
    logic signed [17:0] hz, yaw;
    logic signed [18:0] err;
    logic [18:0]        err_abs;
    always_comb begin
        zr  = r_cz + 21'sd4;
        hz  = zr[20:3];
        yaw = {{2{r_in.own_heading[15]}}, r_in.own_heading};
        if (i_cfg.negate_flags[1]) begin
            yaw = -yaw;
        end
        err = {hz[17], hz} - {yaw[17], yaw};
        for (int k = 0; k < 2; k++) begin
            if (err > PI_Q13) begin
                err = err - TWO_PI_Q13;
            end else if (err < -PI_Q13) begin
                err = err + TWO_PI_Q13;
            end
        end
        err_abs = err[18] ? 19'(-err) : 19'(err);
    end

    // Divide by ten via the reciprocal, then one correction.
    logic [14:0]        q0, q10, tmag;
    logic [17:0]        q0x10, rem10;
    logic signed [15:0] ang;
    always_comb begin
        q0    = r_prod[31:17];
        q0x10 = {q0, 3'b000} + {2'b00, q0, 1'b0};
        rem10 = r_v - q0x10;
        q10   = (rem10 >= 18'd10) ? (q0 + 15'd1) : q0;
        tmag  = (q10 > i_cfg.max_turn_rate) ? i_cfg.max_turn_rate : q10;
        ang   = r_err[18] ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
        if (i_cfg.negate_flags[2]) begin
            ang = -ang;
        end
    end

    // Long division step for speed scaling.
    logic [31:0] dt;
    logic        dt_ge;
    always_comb begin
        dt    = {r_drem, r_dlow[14]};
        dt_ge = (dt >= {1'b0, i_cfg.slowdown_radius});
    end

    logic [14:0]        lmag;
    logic signed [15:0] lin;
    always_comb begin
        if (r_d >= {2'b00, i_cfg.slowdown_radius}) begin
            lmag = i_cfg.max_linear_speed;
        end else if ({r_d, 2'b00} < {4'd0, i_cfg.slowdown_radius}) begin
            lmag = {2'b00, i_cfg.max_linear_speed[14:2]};
        end else begin
            lmag = r_q;
        end
        lin = $signed({1'b0, lmag});
        if (i_cfg.negate_flags[0]) begin
            lin = -lin;
        end
        if (r_abs >= i_cfg.aligned_window) begin
            lin = 16'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x   <= 32'd0;
            r_off_y   <= 32'd0;
            r_latched <= 1'b0;
        end else if (i_cmd.op == OP_LOAD && !r_latched &&
                     i_in.valid_bits[0] && i_in.valid_bits[3]) begin
            r_off_x   <= i_in.anchor_x - i_in.own_x;
            r_off_y   <= i_in.anchor_y - i_in.own_y;
            r_latched <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: r_in <= i_in;
            OP_PREP: begin
                r_dx <= dx;
                r_dy <= dy;
                r_px <= px;
                r_py <= py;
            end
            OP_STOP: r_res <= '{linear_speed: 16'sd0, turn_rate: 16'sd0,
                                drive_status: i_cmd.code};
            OP_SQ_A: begin
                r_acc  <= sq;
                r_rem  <= 34'd0;
                r_root <= 32'd0;
            end
            OP_SQ_B: r_acc <= r_acc + sq;
            OP_ROOT: begin
                r_acc <= {r_acc[61:0], 2'b00};
                if (rt_ge) begin
                    r_rem  <= 34'(rt - trial);
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= rt[33:0];
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
            OP_KEEP_D: r_d <= {r_root, 1'b0};
            OP_CINIT: begin
                if (r_dx[32]) begin
                    r_cx <= -36'(r_dx);
                    r_cy <= -36'(r_dy);
                    r_cz <= r_dy[32] ? -PI_Q16 : PI_Q16;
                end else begin
                    r_cx <= 36'(r_dx);
                    r_cy <= 36'(r_dy);
                    r_cz <= 21'sd0;
                end
            end
            OP_CSTEP: begin
                if (!r_cy[35]) begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + ang_step;
                end else begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - ang_step;
                end
            end
            OP_ERR: begin
                r_err <= err;
                r_abs <= err_abs[14:0];
            end
            OP_MAG_MUL: begin
                r_v    <= {r_abs, 3'b101};
                r_prod <= {r_abs, 3'b101} * RECIP10;
            end
            OP_MAG_FIX:  r_ang <= ang;
            OP_LIN_MUL:  r_num <= i_cfg.max_linear_speed * r_d[30:0];
            OP_DIV_INIT: begin
                r_drem <= r_num[45:15];
                r_dlow <= r_num[14:0];
                r_q    <= 15'd0;
            end
            OP_DIV_STEP: begin
                r_dlow <= {r_dlow[13:0], 1'b0};
                if (dt_ge) begin
                    r_drem <= 31'(dt - {1'b0, i_cfg.slowdown_radius});
                    r_q    <= {r_q[13:0], 1'b1};
                end else begin
                    r_drem <= dt[30:0];
                    r_q    <= {r_q[13:0], 1'b0};
                end
            end
            OP_LIN_FIN: r_res <= '{linear_speed: lin, turn_rate: r_ang,
                                   drive_status: DS_DRIVE};
            default: ;
        endcase
    end

    always_comb begin
        o_stat.ready      = r_in.valid_bits[0] && r_in.valid_bits[2] && r_latched;
        o_stat.near_goal  = ({r_root, 1'b0} <= {2'b00, i_cfg.arrive_radius});
        o_stat.near_peer  = ({r_root, 1'b0} < {2'b00, i_cfg.keep_away_radius});
        o_stat.peer_check = r_in.valid_bits[1] && (i_cfg.keep_away_radius != 31'd0);
    end

    assign o_res = r_res;

endmodule

// File: rtl/core/go_to_goal_velocity_controller.sv
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_stall  i_in  (t_in_item)
// out       output     o_out_valid / i_out_stall o_out (t_out_item)
// config    input      APB psel/penable/pwrite  paddr, pwdata, prdata
//
// One item at a time. A stop for a missing pose or goal (or an offset not yet
// latched) ends the item early; a full tick runs the bit-serial square root for
// the goal, and for the peer too when the separation is checked, then the
// 17-step rotation and the 15-step divide. Reset is synchronous and active
// low; it clears the latched offset. A stalled result holds the block, and
// no new transfer is taken until the result has gone.
module go_to_goal_velocity_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ggvc_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ggvc_pkg::t_out_item o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ggvc_pkg::*;

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    ggvc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ggvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ggvc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (cfg),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (o_out)
    );

endmodule
